// ===== sv/aes_cfb_pkg.sv =====
package aes_cfb_pkg;

  localparam int unsigned BlockW = 128;
  localparam int unsigned HalfW = 64;
  localparam int unsigned NumRounds = 10;
  localparam int unsigned RoundW = 4;
  localparam int unsigned InQueueDepth = 2;
  localparam int unsigned OutQueueDepth = 2;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegKeyHigh = 2'd0,
    RegKeyLow = 2'd1,
    RegIvHigh = 2'd2,
    RegIvLow = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic mode;
    logic [HalfW-1:0] data_high;
    logic [HalfW-1:0] data_low;
    logic last_block;
  } in_item_t;

  typedef struct packed {
    logic [HalfW-1:0] out_high;
    logic [HalfW-1:0] out_low;
    logic out_last;
  } out_item_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte 0 of a block sits in bits 127..120.
  function automatic logic [7:0] get_byte(input logic [BlockW-1:0] b, input int unsigned i);
    return b[BlockW-1-8*i -: 8];
  endfunction

  function automatic logic [BlockW-1:0] next_round_key(input logic [BlockW-1:0] k,
                                                       input logic [7:0] rc);
    logic [31:0] w [4];
    logic [31:0] t;
    logic [BlockW-1:0] r;
    for (int j = 0; j < 4; j++) begin
      w[j] = k[BlockW-1-32*j -: 32];
    end
    t = {Sbox[w[3][23:16]] ^ rc, Sbox[w[3][15:8]], Sbox[w[3][7:0]], Sbox[w[3][31:24]]};
    w[0] = w[0] ^ t;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    r = {w[0], w[1], w[2], w[3]};
    return r;
  endfunction

  function automatic logic [BlockW-1:0] enc_round(input logic [BlockW-1:0] s,
                                                  input logic do_mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [BlockW-1:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i+4*c] = Sbox[get_byte(s, i + 4*((c + i) % 4))];
      end
    end
    if (do_mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[BlockW-1-8*i -: 8] = t[i];
    end
    return r;
  endfunction

endpackage

// ===== sv/aes128_cfb_block_crypt.sv =====
// AES-128 CFB-128 block cipher engine.
// Input side is a queue: present mode_i, data_high_i, data_low_i and last_block_i
// with push; a transfer happens when push is high and full is low.
// Results come out of a queue: while empty is low the oldest result sits on
// out_high_o, out_low_o and out_last_o, and a transfer happens when pop is high.
// Key and IV are written through cfg_valid_i/cfg_ready_o with cfg_index_i
// (0 key high, 1 key low, 2 IV high, 3 IV low); writes are taken at once.
// A block passes through the single round unit as one initial key add and ten
// rounds, round keys expanded on the fly. The finished block leaves the core at
// the same edge that starts the next one; the core takes no new block while it
// is still working on the previous one.
// Blocks chain on the previous ciphertext, so the next block starts only when
// the previous result has entered the result queue.
// If the receiver stalls, the result queue fills, then the core holds its
// finished block and the input queue fills, raising full.
// Reset clears key, IV, chaining state and both queues.
module aes128_cfb_block_crypt #(
  parameter int unsigned InDepth = aes_cfb_pkg::InQueueDepth,
  parameter int unsigned OutDepth = aes_cfb_pkg::OutQueueDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                mode_i,
  input  logic [aes_cfb_pkg::HalfW-1:0]       data_high_i,
  input  logic [aes_cfb_pkg::HalfW-1:0]       data_low_i,
  input  logic                                last_block_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [aes_cfb_pkg::HalfW-1:0]       out_high_o,
  output logic [aes_cfb_pkg::HalfW-1:0]       out_low_o,
  output logic                                out_last_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [aes_cfb_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [aes_cfb_pkg::HalfW-1:0]       cfg_data_i
);
  localparam int unsigned HW = aes_cfb_pkg::HalfW;
  localparam int unsigned InW = $bits(aes_cfb_pkg::in_item_t);
  localparam int unsigned OutW = $bits(aes_cfb_pkg::out_item_t);

  logic [HW-1:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  aes_cfb_pkg::in_item_t in_item, q_item;
  aes_cfb_pkg::out_item_t res, out_item;
  logic q_empty, take, res_valid, res_full;

  assign cfg_ready_o = 1'b1;
  assign in_item = '{mode: mode_i, data_high: data_high_i, data_low: data_low_i,
                     last_block: last_block_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      iv_hi_q <= '0;
      iv_lo_q <= '0;
    end else if (cfg_valid_i) begin
      case (aes_cfb_pkg::cfg_reg_e'(cfg_index_i))
        aes_cfb_pkg::RegKeyHigh: key_hi_q <= cfg_data_i;
        aes_cfb_pkg::RegKeyLow: key_lo_q <= cfg_data_i;
        aes_cfb_pkg::RegIvHigh: iv_hi_q <= cfg_data_i;
        aes_cfb_pkg::RegIvLow: iv_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aes_cfb_fifo #(.Width(InW), .Depth(InDepth)) u_in_q (
    .clk_i, .rst_ni, .wr_i(push), .wdata_i(InW'(in_item)), .full_o(full),
    .rd_i(take), .rdata_o(q_item), .empty_o(q_empty)
  );

  aes_cfb_core u_core (
    .clk_i, .rst_ni,
    .key_i({key_hi_q, key_lo_q}),
    .iv_i({iv_hi_q, iv_lo_q}),
    .item_valid_i(!q_empty),
    .item_i(q_item),
    .item_take_o(take),
    .res_valid_o(res_valid),
    .res_o(res),
    .res_full_i(res_full)
  );

  aes_cfb_fifo #(.Width(OutW), .Depth(OutDepth)) u_out_q (
    .clk_i, .rst_ni, .wr_i(res_valid), .wdata_i(OutW'(res)), .full_o(res_full),
    .rd_i(pop), .rdata_o(out_item), .empty_o(empty)
  );

  assign out_high_o = out_item.out_high;
  assign out_low_o = out_item.out_low;
  assign out_last_o = out_item.out_last;
endmodule

// ===== sv/aes_cfb_fifo.sv =====
module aes_cfb_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0] cnt_q;

  assign full_o = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i && !full_o) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (rd_i && !empty_o) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(wr_i && !full_o) - (PtrW+1)'(rd_i && !empty_o);
    end
  end
endmodule

// ===== sv/aes_cfb_core.sv =====
module aes_cfb_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [aes_cfb_pkg::BlockW-1:0]     key_i,
  input  logic [aes_cfb_pkg::BlockW-1:0]     iv_i,
  input  logic                               item_valid_i,
  input  aes_cfb_pkg::in_item_t              item_i,
  output logic                               item_take_o,
  output logic                               res_valid_o,
  output aes_cfb_pkg::out_item_t             res_o,
  input  logic                               res_full_i
);
  localparam int unsigned BW = aes_cfb_pkg::BlockW;
  localparam int unsigned HW = aes_cfb_pkg::HalfW;
  localparam int unsigned RW = aes_cfb_pkg::RoundW;

  logic busy_q, busy_d, done_q, done_d, chain_q, chain_d;
  logic [RW-1:0] rnd_q, rnd_d;
  logic [7:0] rc_q, rc_d;
  logic [BW-1:0] st_q, st_d, rk_q, rk_d, fb_q, fb_d, data_q, data_d;
  logic mode_q, mode_d, last_q, last_d;
  logic [BW-1:0] rk_next, ks, res;

  assign rk_next = aes_cfb_pkg::next_round_key(rk_q, rc_q);
  assign ks = st_q;
  assign res = data_q ^ ks;
  assign res_valid_o = done_q && !res_full_i;
  assign res_o = '{out_high: res[BW-1:HW], out_low: res[HW-1:0], out_last: last_q};
  assign item_take_o = item_valid_i && (!busy_q && (!done_q || !res_full_i));

  always_comb begin
    busy_d = busy_q; done_d = done_q; chain_d = chain_q;
    rnd_d = rnd_q; rc_d = rc_q; st_d = st_q; rk_d = rk_q; fb_d = fb_q;
    data_d = data_q; mode_d = mode_q; last_d = last_q;
    if (done_q && !res_full_i) begin
      done_d = 1'b0;
      chain_d = !last_q;
      if (!last_q) begin
        fb_d = mode_q ? data_q : res;
      end
    end
    if (busy_q) begin
      st_d = aes_cfb_pkg::enc_round(st_q, rnd_q != RW'(aes_cfb_pkg::NumRounds)) ^ rk_next;
      rk_d = rk_next;
      rc_d = aes_cfb_pkg::xtime(rc_q);
      rnd_d = rnd_q + 1'b1;
      if (rnd_q == RW'(aes_cfb_pkg::NumRounds)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
    if (item_take_o) begin
      busy_d = 1'b1;
      rnd_d = RW'(1);
      rc_d = 8'h01;
      rk_d = key_i;
      st_d = (chain_d ? fb_d : iv_i) ^ key_i;
      data_d = {item_i.data_high, item_i.data_low};
      mode_d = item_i.mode;
      last_d = item_i.last_block;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      chain_q <= 1'b0;
      fb_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      chain_q <= chain_d;
      fb_q <= fb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q <= rnd_d;
    rc_q <= rc_d;
    st_q <= st_d;
    rk_q <= rk_d;
    data_q <= data_d;
    mode_q <= mode_d;
    last_q <= last_d;
  end
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic                          mode;
    logic [aes_cfb_pkg::HalfW-1:0] hi;
    logic [aes_cfb_pkg::HalfW-1:0] lo;
    logic                          last;
    bit                            typed;
    logic [aes_cfb_pkg::HalfW-1:0] exp_hi;
    logic [aes_cfb_pkg::HalfW-1:0] exp_lo;
  } block_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic mode_i = 1'b0;
  logic [aes_cfb_pkg::HalfW-1:0] data_high_i = '0;
  logic [aes_cfb_pkg::HalfW-1:0] data_low_i = '0;
  logic last_block_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [aes_cfb_pkg::HalfW-1:0] out_high_o;
  logic [aes_cfb_pkg::HalfW-1:0] out_low_o;
  logic out_last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [aes_cfb_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [aes_cfb_pkg::HalfW-1:0] cfg_data_i = '0;

  logic [aes_cfb_pkg::BlockW-1:0] key_q, iv_q, feedback_q;
  bit chain_on;
  aes_cfb_pkg::out_item_t cipher_q[$];
  int unsigned errors, blocks_sent, blocks_seen, cfg_writes;
  bit no_idle;

  aes128_cfb_block_crypt DUT (.*);

  always #6 clk_i = ~clk_i;

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [aes_cfb_pkg::BlockW-1:0] aes_encipher(
      input logic [aes_cfb_pkg::BlockW-1:0] key,
      input logic [aes_cfb_pkg::BlockW-1:0] pt);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] rk [16];
    logic [7:0] tmp [4];
    logic [7:0] rc, x;
    logic [aes_cfb_pkg::BlockW-1:0] ct;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[aes_cfb_pkg::BlockW-1-8*i -: 8];
      s[i] = pt[aes_cfb_pkg::BlockW-1-8*i -: 8] ^ rk[i];
    end
    for (int r = 1; r <= aes_cfb_pkg::NumRounds; r++) begin
      tmp[0] = aes_cfb_pkg::Sbox[rk[13]] ^ rc;
      tmp[1] = aes_cfb_pkg::Sbox[rk[14]];
      tmp[2] = aes_cfb_pkg::Sbox[rk[15]];
      tmp[3] = aes_cfb_pkg::Sbox[rk[12]];
      for (int j = 0; j < 4; j++) rk[j] = rk[j] ^ tmp[j];
      for (int j = 4; j < 16; j++) rk[j] = rk[j] ^ rk[j-4];
      rc = gf_dbl(rc);
      for (int c = 0; c < 4; c++) begin
        for (int i = 0; i < 4; i++) t[i+4*c] = aes_cfb_pkg::Sbox[s[i+4*((c+i)%4)]];
      end
      if (r < aes_cfb_pkg::NumRounds) begin
        for (int c = 0; c < 4; c++) begin
          x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
          tmp[0] = t[4*c] ^ x ^ gf_dbl(t[4*c] ^ t[4*c+1]);
          tmp[1] = t[4*c+1] ^ x ^ gf_dbl(t[4*c+1] ^ t[4*c+2]);
          tmp[2] = t[4*c+2] ^ x ^ gf_dbl(t[4*c+2] ^ t[4*c+3]);
          tmp[3] = t[4*c+3] ^ x ^ gf_dbl(t[4*c+3] ^ t[4*c]);
          for (int j = 0; j < 4; j++) t[4*c+j] = tmp[j];
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) ct[aes_cfb_pkg::BlockW-1-8*i -: 8] = s[i];
    return ct;
  endfunction

  function automatic aes_cfb_pkg::out_item_t cfb_next(
      input logic m, input logic [aes_cfb_pkg::HalfW-1:0] hi,
      input logic [aes_cfb_pkg::HalfW-1:0] lo, input logic last);
    logic [aes_cfb_pkg::BlockW-1:0] ks, res;
    aes_cfb_pkg::out_item_t o;
    ks = aes_encipher(key_q, chain_on ? feedback_q : iv_q);
    res = {hi, lo} ^ ks;
    if (last) begin
      chain_on = 1'b0;
    end else begin
      feedback_q = m ? {hi, lo} : res;
      chain_on = 1'b1;
    end
    o.out_high = res[aes_cfb_pkg::BlockW-1 -: aes_cfb_pkg::HalfW];
    o.out_low = res[aes_cfb_pkg::HalfW-1:0];
    o.out_last = last;
    return o;
  endfunction

  task automatic send_block(input logic m, input logic [aes_cfb_pkg::HalfW-1:0] hi,
                            input logic [aes_cfb_pkg::HalfW-1:0] lo, input logic last);
    bit done;
    done = 0;
    while (!done) begin
      @(negedge clk_i);
      if (!no_idle && $urandom_range(99) < 18) begin
        push = 1'b0;
      end else begin
        push = 1'b1;
        mode_i = m;
        data_high_i = hi;
        data_low_i = lo;
        last_block_i = last;
        @(posedge clk_i);
        while (full) @(posedge clk_i);
        cipher_q.push_back(cfb_next(m, hi, lo, last));
        blocks_sent++;
        done = 1;
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    push = 1'b0;
    while (cipher_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(input aes_cfb_pkg::cfg_reg_e idx,
                           input logic [aes_cfb_pkg::HalfW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      aes_cfb_pkg::RegKeyHigh:
        key_q[aes_cfb_pkg::BlockW-1 -: aes_cfb_pkg::HalfW] = val;
      aes_cfb_pkg::RegKeyLow:  key_q[aes_cfb_pkg::HalfW-1:0] = val;
      aes_cfb_pkg::RegIvHigh:
        iv_q[aes_cfb_pkg::BlockW-1 -: aes_cfb_pkg::HalfW] = val;
      aes_cfb_pkg::RegIvLow:   iv_q[aes_cfb_pkg::HalfW-1:0] = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [aes_cfb_pkg::HalfW-1:0] rand_half();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  always @(negedge clk_i) begin
    pop = no_idle || $urandom_range(99) >= 18;
  end

  always @(posedge clk_i) begin
    aes_cfb_pkg::out_item_t e;
    if (rst_ni && !empty && pop) begin
      blocks_seen++;
      if (cipher_q.size() == 0) begin
        $display("%0t: result with none expected: %h %h %b", $time,
                 out_high_o, out_low_o, out_last_o);
        errors++;
      end else begin
        e = cipher_q.pop_front();
        if (out_high_o !== e.out_high) begin
          $display("%0t: out_high expected %h actual %h", $time, e.out_high, out_high_o);
          errors++;
        end
        if (out_low_o !== e.out_low) begin
          $display("%0t: out_low expected %h actual %h", $time, e.out_low, out_low_o);
          errors++;
        end
        if (out_last_o !== e.out_last) begin
          $display("%0t: out_last expected %b actual %b", $time, e.out_last, out_last_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    block_row_t rows [$];
    logic [aes_cfb_pkg::HalfW-1:0] kv [4];
    aes_cfb_pkg::out_item_t want;
    key_q = '0;
    iv_q = '0;
    feedback_q = '0;
    chain_on = 0;
    errors = 0;
    no_idle = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The all-zero block under the all-zero key gives the well-known ciphertext.
    rows = '{
      '{1'b0, 64'h0, 64'h0, 1'b1, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
      '{1'b0, '1, '1, 1'b1, 1, ~64'h66e94bd4ef8a2c3b, ~64'h884cfa59ca342b2e},
      '{1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1, 1, 64'h0, 64'h0},
      '{1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 0, 0, 0},
      '{1'b0, '1, 64'h0, 1'b0, 0, 0, 0},
      '{1'b0, 64'h8000000000000001, 64'h1, 1'b1, 0, 0, 0},
      '{1'b1, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 0, 0, 0},
      '{1'b1, 64'h0, '1, 1'b0, 0, 0, 0},
      '{1'b1, '1, '1, 1'b0, 0, 0, 0}
    };
    foreach (rows[i]) begin
      want.out_high = rows[i].exp_hi;
      want.out_low = rows[i].exp_lo;
      send_block(rows[i].mode, rows[i].hi, rows[i].lo, rows[i].last);
      if (rows[i].typed && (cipher_q[$].out_high !== want.out_high ||
                            cipher_q[$].out_low !== want.out_low)) begin
        $display("%0t: row %0d predictor expected %h%h actual %h%h", $time, i,
                 want.out_high, want.out_low, cipher_q[$].out_high, cipher_q[$].out_low);
        errors++;
      end
    end

    // The chain is still open here: a new key applies at once, a new IV only
    // after the chain ends.
    drain_results();
    write_reg(aes_cfb_pkg::RegKeyHigh, 64'h2b7e151628aed2a6);
    write_reg(aes_cfb_pkg::RegKeyLow, 64'habf7158809cf4f3c);
    write_reg(aes_cfb_pkg::RegIvHigh, 64'h0001020304050607);
    write_reg(aes_cfb_pkg::RegIvLow, 64'h08090a0b0c0d0e0f);
    send_block(1'b0, 64'h6bc1bee22e409f96, 64'he93d7e117393172a, 1'b1);
    send_block(1'b0, 64'h6bc1bee22e409f96, 64'he93d7e117393172a, 1'b0);
    send_block(1'b0, 64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 1'b1);
    send_block(1'b1, 64'h3b3fd92eb72dad20, 64'h333449f8e83cfb4a, 1'b0);
    send_block(1'b1, 64'hc8a64537a0b3a93f, 64'hcde3cdad9f1ce58b, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        0: kv = '{'1, '1, '1, '1};
        1: kv = '{'0, '0, '0, '0};
        default: kv = '{rand_half(), rand_half(), rand_half(), rand_half()};
      endcase
      write_reg(aes_cfb_pkg::RegKeyHigh, kv[0]);
      write_reg(aes_cfb_pkg::RegKeyLow, kv[1]);
      write_reg(aes_cfb_pkg::RegIvHigh, kv[2]);
      write_reg(aes_cfb_pkg::RegIvLow, kv[3]);
      for (int n = 0; n < 420; n++) begin
        no_idle = (ph == 2 && n >= 100 && n < 250);
        send_block(1'($urandom_range(1)), rand_half(), rand_half(),
                   $urandom_range(4) == 0);
      end
      no_idle = 0;
    end

    drain_results();
    $display("Sent %0d blocks and checked %0d results across %0d register writes,",
             blocks_sent, blocks_seen, cfg_writes);
    $display("covering both modes, open and closed chains and extreme keys and IVs.");
    if (errors == 0 && cipher_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/aes_cfb_pkg.sv
sv/aes_cfb_fifo.sv
sv/aes_cfb_core.sv
sv/aes128_cfb_block_crypt.sv
bench/tb.sv
